>>> rtl/core/afk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afk_pkg
// Shared constants, register codes and fixed-point helpers for the arm
// forward kinematics pipeline.
// ----------------------------------------------------------------------------
package afk_pkg;

   localparam int CORDIC_STAGES_DEF = 24;

   localparam int REQ_W = 160;
   localparam int RSP_W = 352;

   typedef enum logic [2:0] {
      CSR_BASE_HEIGHT      = 3'd0,
      CSR_UPPER_ARM_LENGTH = 3'd1,
      CSR_FOREARM_LENGTH   = 3'd2,
      CSR_TOOL_REACH       = 3'd3,
      CSR_TOOL_SIDE_SHIFT  = 3'd4
   } csr_index_type;

   // Q2.30 angle constants
   localparam logic signed [36:0] PI_Q30      = 37'sd3373259426;
   localparam logic signed [36:0] TWO_PI_Q30  = 37'sd6746518852;
   localparam logic signed [36:0] HALF_PI_Q30 = 37'sd1686629713;
   localparam logic signed [32:0] GAIN_Q30    = 33'sd652032874;
   localparam logic signed [31:0] ONE_Q30     = 32'sd1073741824;
   localparam logic [31:0]        YAW_EPS_Q30 = 32'd1073;
   localparam logic signed [31:0] PITCH_LIM   = 32'sd421657428;
   localparam logic signed [31:0] YAW_LO      = -32'sd843314856;
   localparam logic signed [31:0] YAW_HI      = 32'sd843314857;

   // atan(2^-i), Q2.30, truncated
   localparam logic [29:0] ATAN_TABLE [32] = '{
      30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
      30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
      30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535, 30'd32767,
      30'd16383, 30'd8191, 30'd4095, 30'd2047, 30'd1023, 30'd511, 30'd255,
      30'd127, 30'd63, 30'd31, 30'd15, 30'd7, 30'd3, 30'd1, 30'd0, 30'd0
   };

   // Q30 product, round half up: (a*b + 2^29) >>> 30
   function automatic logic signed [37:0] mq(input logic signed [33:0] a,
                                             input logic signed [33:0] b);
      logic signed [67:0] p;
      p = 68'(a) * 68'(b) + 68'sd536870912;
      return 38'(p >>> 30);
   endfunction

   function automatic logic signed [31:0] clamp_q30(input logic signed [37:0] v);
      if (v > 38'(ONE_Q30)) begin
         return ONE_Q30;
      end else if (v < -38'(ONE_Q30)) begin
         return -ONE_Q30;
      end
      return 32'(v);
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
      if (v > 38'sd2147483647) begin
         return 32'sh7FFFFFFF;
      end else if (v < -38'sd2147483648) begin
         return 32'sh80000000;
      end
      return 32'(v);
   endfunction

endpackage

>>> rtl/core/afk_rot_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afk_rot_cordic
// Pipelined sine/cosine: range reduction, half-turn fold, rotation CORDIC.
// ----------------------------------------------------------------------------
module afk_rot_cordic import afk_pkg::*; #(
   parameter int STAGES = CORDIC_STAGES_DEF
) (
   input  logic               clock,
   input  logic               en,
   input  logic signed [32:0] angle,     // Q3.28
   output logic signed [31:0] sin_out,   // Q1.30
   output logic signed [31:0] cos_out    // Q1.30
);

   logic signed [34:0] scaled_ff;
   logic signed [32:0] reduced_ff;
   logic signed [32:0] reduced_in;
   logic signed [33:0] folded_in;
   logic               neg_in;
   logic signed [33:0] ang_ff [STAGES+1];
   logic signed [32:0] x_ff [STAGES+1];
   logic signed [32:0] y_ff [STAGES+1];
   logic               neg_ff [STAGES+1];
   logic signed [32:0] x_fin;
   logic signed [32:0] y_fin;
   logic signed [31:0] sin_ff;
   logic signed [31:0] cos_ff;

   // wrap into (-pi, pi]; three whole turns at most
   always_comb begin
      logic signed [36:0] cand;
      reduced_in = '0;
      for (int k = -3; k <= 3; k++) begin
         cand = 37'(scaled_ff) - 37'(k) * TWO_PI_Q30;
         if (cand > -PI_Q30 && cand <= PI_Q30) begin
            reduced_in = 33'(cand);
         end
      end
   end

   always_comb begin
      folded_in = 34'(reduced_ff);
      neg_in    = 1'b0;
      if (37'(reduced_ff) > HALF_PI_Q30) begin
         folded_in = 34'(37'(reduced_ff) - PI_Q30);
         neg_in    = 1'b1;
      end else if (37'(reduced_ff) < -HALF_PI_Q30) begin
         folded_in = 34'(37'(reduced_ff) + PI_Q30);
         neg_in    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         scaled_ff  <= {angle, 2'b00};
         reduced_ff <= reduced_in;
         ang_ff[0]  <= folded_in;
         x_ff[0]    <= GAIN_Q30;
         y_ff[0]    <= '0;
         neg_ff[0]  <= neg_in;
      end
   end

   for (genvar g = 0; g < STAGES; g++) begin : g_iter
      logic signed [32:0] xs;
      logic signed [32:0] ys;
      logic signed [33:0] step;
      assign xs   = x_ff[g] >>> g;
      assign ys   = y_ff[g] >>> g;
      assign step = $signed({4'b0000, ATAN_TABLE[g]});
      always_ff @(posedge clock) begin
         if (en) begin
            if (ang_ff[g] >= 0) begin
               x_ff[g+1]   <= x_ff[g] - ys;
               y_ff[g+1]   <= y_ff[g] + xs;
               ang_ff[g+1] <= ang_ff[g] - step;
            end else begin
               x_ff[g+1]   <= x_ff[g] + ys;
               y_ff[g+1]   <= y_ff[g] - xs;
               ang_ff[g+1] <= ang_ff[g] + step;
            end
            neg_ff[g+1] <= neg_ff[g];
         end
      end
   end

   assign x_fin = neg_ff[STAGES] ? -x_ff[STAGES] : x_ff[STAGES];
   assign y_fin = neg_ff[STAGES] ? -y_ff[STAGES] : y_ff[STAGES];

   always_ff @(posedge clock) begin
      if (en) begin
         cos_ff <= clamp_q30(38'(x_fin));
         sin_ff <= clamp_q30(38'(y_fin));
      end
   end

   assign sin_out = sin_ff;
   assign cos_out = cos_ff;

endmodule

>>> rtl/core/afk_vec_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afk_vec_cordic
// Pipelined atan2 by vectoring CORDIC, result wrapped to (-pi, pi] and
// rounded to Q3.28.
// ----------------------------------------------------------------------------
module afk_vec_cordic import afk_pkg::*; #(
   parameter int STAGES = CORDIC_STAGES_DEF
) (
   input  logic               clock,
   input  logic               en,
   input  logic signed [31:0] y_in,     // |y| <= 2^30
   input  logic signed [31:0] x_in,     // |x| <= 2^30
   output logic signed [31:0] angle     // Q3.28
);

   logic signed [33:0] x_ff [STAGES+1];
   logic signed [33:0] y_ff [STAGES+1];
   logic signed [34:0] z_ff [STAGES+1];
   logic signed [36:0] wrap_a;
   logic signed [36:0] wrap_b;
   logic signed [31:0] angle_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (x_in < 0) begin
            x_ff[0] <= -34'(x_in);
            y_ff[0] <= -34'(y_in);
            z_ff[0] <= (y_in >= 0) ? 35'(PI_Q30) : -35'(PI_Q30);
         end else begin
            x_ff[0] <= 34'(x_in);
            y_ff[0] <= 34'(y_in);
            z_ff[0] <= '0;
         end
      end
   end

   for (genvar g = 0; g < STAGES; g++) begin : g_iter
      logic signed [33:0] xs;
      logic signed [33:0] ys;
      logic signed [34:0] step;
      assign xs   = x_ff[g] >>> g;
      assign ys   = y_ff[g] >>> g;
      assign step = $signed({5'b00000, ATAN_TABLE[g]});
      always_ff @(posedge clock) begin
         if (en) begin
            if (y_ff[g] > 0) begin
               x_ff[g+1] <= x_ff[g] + ys;
               y_ff[g+1] <= y_ff[g] - xs;
               z_ff[g+1] <= z_ff[g] + step;
            end else begin
               x_ff[g+1] <= x_ff[g] - ys;
               y_ff[g+1] <= y_ff[g] + xs;
               z_ff[g+1] <= z_ff[g] - step;
            end
         end
      end
   end

   assign wrap_a = (37'(z_ff[STAGES]) > PI_Q30) ? 37'(z_ff[STAGES]) - TWO_PI_Q30
                                                : 37'(z_ff[STAGES]);
   assign wrap_b = (wrap_a <= -PI_Q30) ? wrap_a + TWO_PI_Q30 : wrap_a;

   always_ff @(posedge clock) begin
      if (en) begin
         angle_ff <= 32'((wrap_b + 37'sd2) >>> 2);
      end
   end

   assign angle = angle_ff;

endmodule

>>> rtl/core/arm_forward_kinematics.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arm_forward_kinematics
// Five-joint arm forward kinematics: tool point, approach and pitch-axis
// unit vectors, approach pitch and yaw, as one deep pipeline.
// ----------------------------------------------------------------------------
//
//  port group  direction  payload
//  req_*       in         five joint angles, Q3.28
//  rsp_*       out        tool point, pitch, yaw, approach and axis vectors
//  csr_*       in         link register writes, always ready
//
//  One item per cycle while the output buffer has a free entry. The path runs
//  the sine/cosine CORDIC, the 31-step square root and the atan2 CORDIC in
//  series. Reset (synchronous) empties the pipeline and the two-entry output
//  buffer and loads the link defaults. The pipeline moves while the output
//  buffer has a free entry, so inputs keep flowing while one result waits.
// ----------------------------------------------------------------------------
module arm_forward_kinematics import afk_pkg::*; #(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // base_angle, shoulder_angle, elbow_angle, roll_angle, pitch_angle
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // tool_x, tool_y, tool_z, approach_pitch(30), approach_yaw(31),
   // approach_x/y/z, axis_x/y/z, 3 zero bits
   output logic [RSP_W-1:0] rsp_tdata,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [31:0]      csr_data
);

   localparam int LROT     = CORDIC_STAGES + 4;
   localparam int LVEC     = CORDIC_STAGES + 2;
   localparam int LAST     = LROT + 34 + LVEC;
   localparam int YAW_DLY  = 32;
   localparam int HOLD_DLY = LVEC + 31;
   localparam int SQ_STEPS = 31;

   typedef struct packed {
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] pz;
      logic signed [31:0] ax;
      logic signed [31:0] ay;
      logic signed [31:0] az;
      logic signed [31:0] nx;
      logic signed [31:0] ny;
      logic signed [31:0] nz;
      logic               yaw_zero;
   } hold_type;

   // link registers
   logic [30:0]        bh_ff;
   logic [30:0]        ua_ff;
   logic [30:0]        fa_ff;
   logic [30:0]        tr_ff;
   logic signed [31:0] ts_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bh_ff <= '0;
         ua_ff <= 31'd65536;
         fa_ff <= 31'd65536;
         tr_ff <= '0;
         ts_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_BASE_HEIGHT:      bh_ff <= csr_data[30:0];
            CSR_UPPER_ARM_LENGTH: ua_ff <= csr_data[30:0];
            CSR_FOREARM_LENGTH:   fa_ff <= csr_data[30:0];
            CSR_TOOL_REACH:       tr_ff <= csr_data[30:0];
            CSR_TOOL_SIDE_SHIFT:  ts_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // pipeline advance and output buffer
   logic [1:0]       count_ff;
   logic [RSP_W-1:0] ent0_ff;
   logic [RSP_W-1:0] ent1_ff;
   logic             en;
   logic             push;
   logic             pop;
   logic [LAST:0]    vld_ff;
   logic [RSP_W-1:0] rsp_word;

   assign en         = (count_ff != 2'd2);
   assign req_tready = en;
   assign push       = en && vld_ff[LAST];
   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_tdata  = ent0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff   <= '0;
         count_ff <= '0;
      end else begin
         if (en) begin
            vld_ff <= {vld_ff[LAST-1:0], req_tvalid};
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && !push) begin
         ent0_ff <= ent1_ff;
      end else if (push && !pop) begin
         if (count_ff == 2'd0) begin
            ent0_ff <= rsp_word;
         end else begin
            ent1_ff <= rsp_word;
         end
      end else if (push && pop) begin
         if (count_ff == 2'd1) begin
            ent0_ff <= rsp_word;
         end else begin
            ent0_ff <= ent1_ff;
            ent1_ff <= rsp_word;
         end
      end
   end

   // input register
   logic signed [31:0] q1_ff;
   logic signed [31:0] q2_ff;
   logic signed [31:0] q3_ff;
   logic signed [31:0] q4_ff;
   logic signed [31:0] q5_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         q1_ff <= req_tdata[31:0];
         q2_ff <= req_tdata[63:32];
         q3_ff <= req_tdata[95:64];
         q4_ff <= req_tdata[127:96];
         q5_ff <= req_tdata[159:128];
      end
   end

   // trig
   logic signed [31:0] s1, c1, s2, c2, sp, cp, s4, c4, s5, c5;
   logic signed [32:0] q23;

   assign q23 = 33'(q2_ff) + 33'(q3_ff);

   afk_rot_cordic #(.STAGES(CORDIC_STAGES)) u_rot_base (
      .clock(clock), .en(en), .angle(33'(q1_ff)), .sin_out(s1), .cos_out(c1));
   afk_rot_cordic #(.STAGES(CORDIC_STAGES)) u_rot_shoulder (
      .clock(clock), .en(en), .angle(33'(q2_ff)), .sin_out(s2), .cos_out(c2));
   afk_rot_cordic #(.STAGES(CORDIC_STAGES)) u_rot_forearm (
      .clock(clock), .en(en), .angle(q23), .sin_out(sp), .cos_out(cp));
   afk_rot_cordic #(.STAGES(CORDIC_STAGES)) u_rot_roll (
      .clock(clock), .en(en), .angle(33'(q4_ff)), .sin_out(s4), .cos_out(c4));
   afk_rot_cordic #(.STAGES(CORDIC_STAGES)) u_rot_pitch (
      .clock(clock), .en(en), .angle(33'(q5_ff)), .sin_out(s5), .cos_out(c5));

   // first product level: forearm direction, roll terms, link projections
   logic signed [31:0] fx_ff, fy_ff, ux_ff, uy_ff, k_ff, m_ff;
   logic signed [32:0] ra_ff, rb_ff, za_ff, zb_ff;
   logic signed [31:0] s1_m1_ff, c1_m1_ff, sp_m1_ff, cp_m1_ff;
   logic signed [31:0] s4_m1_ff, c4_m1_ff, c5_m1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         fx_ff    <= 32'(mq(34'(cp), 34'(c1)));
         fy_ff    <= 32'(mq(34'(cp), 34'(s1)));
         ux_ff    <= 32'(-mq(34'(sp), 34'(c1)));
         uy_ff    <= 32'(-mq(34'(sp), 34'(s1)));
         k_ff     <= 32'(mq(34'(s5), 34'(c4)));
         m_ff     <= 32'(mq(34'(s5), 34'(s4)));
         ra_ff    <= 33'(mq(34'(ua_ff), 34'(c2)));
         rb_ff    <= 33'(mq(34'(fa_ff), 34'(cp)));
         za_ff    <= 33'(mq(34'(ua_ff), 34'(s2)));
         zb_ff    <= 33'(mq(34'(fa_ff), 34'(sp)));
         s1_m1_ff <= s1;
         c1_m1_ff <= c1;
         sp_m1_ff <= sp;
         cp_m1_ff <= cp;
         s4_m1_ff <= s4;
         c4_m1_ff <= c4;
         c5_m1_ff <= c5;
      end
   end

   // second level: unit vectors, wrist center
   logic signed [31:0] ax_ff, ay_ff, az_ff, nx_ff, ny_ff, nz_ff;
   logic signed [33:0] r_ff;
   logic signed [34:0] z_ff;
   logic signed [31:0] s1_m2_ff, c1_m2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         ax_ff <= clamp_q30(mq(34'(c5_m1_ff), 34'(fx_ff)) + mq(34'(k_ff), 34'(ux_ff))
                            + mq(34'(m_ff), 34'(s1_m1_ff)));
         ay_ff <= clamp_q30(mq(34'(c5_m1_ff), 34'(fy_ff)) + mq(34'(k_ff), 34'(uy_ff))
                            - mq(34'(m_ff), 34'(c1_m1_ff)));
         az_ff <= clamp_q30(mq(34'(c5_m1_ff), 34'(sp_m1_ff))
                            + mq(34'(k_ff), 34'(cp_m1_ff)));
         nx_ff <= clamp_q30(-mq(34'(c4_m1_ff), 34'(s1_m1_ff))
                            + mq(34'(s4_m1_ff), 34'(ux_ff)));
         ny_ff <= clamp_q30(mq(34'(c4_m1_ff), 34'(c1_m1_ff))
                            + mq(34'(s4_m1_ff), 34'(uy_ff)));
         nz_ff <= clamp_q30(mq(34'(s4_m1_ff), 34'(cp_m1_ff)));
         r_ff  <= 34'(ra_ff) + 34'(rb_ff);
         z_ff  <= $signed({4'b0000, bh_ff}) + 35'(za_ff) + 35'(zb_ff);
         s1_m2_ff <= s1_m1_ff;
         c1_m2_ff <= c1_m1_ff;
      end
   end

   // third level: tool offsets, pitch radicand, vertical test
   logic signed [37:0] prx_ff, pry_ff, zc_ff;
   logic signed [37:0] tsx_ff, tsy_ff, tsz_ff, tlx_ff, tly_ff, tlz_ff;
   logic signed [31:0] ax_m3_ff, ay_m3_ff, az_m3_ff, nx_m3_ff, ny_m3_ff, nz_m3_ff;
   logic               yaw_zero_ff;
   logic signed [63:0] vv;
   logic [31:0]        abs_x;
   logic [31:0]        abs_y;
   logic [61:0]        sq_op_ff [SQ_STEPS+1];
   logic [61:0]        sq_res_ff [SQ_STEPS+1];
   logic signed [31:0] sq_v_ff [SQ_STEPS+1];

   localparam logic signed [63:0] ONE_SQ = 64'sd1 <<< 60;

   assign vv    = 64'(az_ff) * 64'(az_ff);
   assign abs_x = (ax_ff < 0) ? 32'(-ax_ff) : 32'(ax_ff);
   assign abs_y = (ay_ff < 0) ? 32'(-ay_ff) : 32'(ay_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         prx_ff <= mq(r_ff, 34'(c1_m2_ff));
         pry_ff <= mq(r_ff, 34'(s1_m2_ff));
         zc_ff  <= 38'(z_ff);
         tsx_ff <= mq(34'(ts_ff), 34'(nx_ff));
         tsy_ff <= mq(34'(ts_ff), 34'(ny_ff));
         tsz_ff <= mq(34'(ts_ff), 34'(nz_ff));
         tlx_ff <= mq(34'({1'b0, tr_ff}), 34'(ax_ff));
         tly_ff <= mq(34'({1'b0, tr_ff}), 34'(ay_ff));
         tlz_ff <= mq(34'({1'b0, tr_ff}), 34'(az_ff));
         ax_m3_ff <= ax_ff;
         ay_m3_ff <= ay_ff;
         az_m3_ff <= az_ff;
         nx_m3_ff <= nx_ff;
         ny_m3_ff <= ny_ff;
         nz_m3_ff <= nz_ff;
         yaw_zero_ff  <= (abs_x + abs_y) <= YAW_EPS_Q30;
         sq_op_ff[0]  <= 62'(ONE_SQ - vv);
         sq_res_ff[0] <= '0;
         sq_v_ff[0]   <= az_ff;
      end
   end

   // square root, one result bit per stage
   for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sqrt
      localparam logic [61:0] BIT_K = 62'd1 << (60 - 2 * g);
      logic [61:0] trial;
      assign trial = sq_res_ff[g] + BIT_K;
      always_ff @(posedge clock) begin
         if (en) begin
            if (sq_op_ff[g] >= trial) begin
               sq_op_ff[g+1]  <= sq_op_ff[g] - trial;
               sq_res_ff[g+1] <= (sq_res_ff[g] >> 1) + BIT_K;
            end else begin
               sq_op_ff[g+1]  <= sq_op_ff[g];
               sq_res_ff[g+1] <= sq_res_ff[g] >> 1;
            end
            sq_v_ff[g+1] <= sq_v_ff[g];
         end
      end
   end

   logic signed [31:0] pitch_raw;
   logic signed [31:0] yaw_raw;

   afk_vec_cordic #(.STAGES(CORDIC_STAGES)) u_vec_pitch (
      .clock(clock), .en(en), .y_in(sq_v_ff[SQ_STEPS]),
      .x_in(32'(sq_res_ff[SQ_STEPS])), .angle(pitch_raw));

   afk_vec_cordic #(.STAGES(CORDIC_STAGES)) u_vec_yaw (
      .clock(clock), .en(en), .y_in(ay_ff), .x_in(ax_ff), .angle(yaw_raw));

   // alignment lines
   logic signed [31:0] yaw_dl_ff [YAW_DLY];
   hold_type           hold_dl_ff [HOLD_DLY];
   hold_type           hold_in;

   always_comb begin
      hold_in.px       = sat32(prx_ff + tsx_ff + tlx_ff);
      hold_in.py       = sat32(pry_ff + tsy_ff + tly_ff);
      hold_in.pz       = sat32(zc_ff + tsz_ff + tlz_ff);
      hold_in.ax       = ax_m3_ff;
      hold_in.ay       = ay_m3_ff;
      hold_in.az       = az_m3_ff;
      hold_in.nx       = nx_m3_ff;
      hold_in.ny       = ny_m3_ff;
      hold_in.nz       = nz_m3_ff;
      hold_in.yaw_zero = yaw_zero_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         yaw_dl_ff[0]  <= yaw_raw;
         hold_dl_ff[0] <= hold_in;
         for (int j = 1; j < YAW_DLY; j++) begin
            yaw_dl_ff[j] <= yaw_dl_ff[j-1];
         end
         for (int j = 1; j < HOLD_DLY; j++) begin
            hold_dl_ff[j] <= hold_dl_ff[j-1];
         end
      end
   end

   // final clamp and pack
   hold_type           hold_out;
   logic signed [31:0] yaw_out;
   logic signed [31:0] pitch_c;
   logic signed [31:0] yaw_c;

   assign hold_out = hold_dl_ff[HOLD_DLY-1];
   assign yaw_out  = yaw_dl_ff[YAW_DLY-1];

   always_comb begin
      pitch_c = pitch_raw;
      if (pitch_raw > PITCH_LIM) begin
         pitch_c = PITCH_LIM;
      end else if (pitch_raw < -PITCH_LIM) begin
         pitch_c = -PITCH_LIM;
      end
      yaw_c = yaw_out;
      if (hold_out.yaw_zero) begin
         yaw_c = '0;
      end else if (yaw_out > YAW_HI) begin
         yaw_c = YAW_HI;
      end else if (yaw_out < YAW_LO) begin
         yaw_c = YAW_LO;
      end
      rsp_word = {3'b000, hold_out.nz, hold_out.ny, hold_out.nx,
                  hold_out.az, hold_out.ay, hold_out.ax,
                  yaw_c[30:0], pitch_c[29:0],
                  hold_out.pz, hold_out.py, hold_out.px};
   end

endmodule
